[rtl/ordered_list_engine_assert.svh]
// Assertion macros for the ordered list engine.
// The macros expect signals named clk and rst_n in the scope where they are used.
`ifndef ORDERED_LIST_ENGINE_ASSERT_SVH
`define ORDERED_LIST_ENGINE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define OLE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ordered_list_engine: same-cycle check failed");
// next-cycle implication
`define OLE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ordered_list_engine: next-cycle check failed");
`else
`define OLE_ASSERT_IMP(lbl, ante, cons)
`define OLE_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

[rtl/ole_pkg.sv]
package ole_pkg;

  // field widths
  localparam int KIND_W = 2;
  localparam int POS_W  = 4;
  localparam int VAL_W  = 32;
  localparam int STAT_W = 2;
  localparam int CNT_W  = 5;

  // stream payload widths, rounded up to whole bytes
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 48;

  // command kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_APPEND = 2'd0,
    KIND_READ   = 2'd1,
    KIND_DELETE = 2'd2,
    KIND_FIND   = 2'd3
  } kind_t;

  // result status codes
  localparam logic [STAT_W-1:0] ST_DONE = 2'd0;
  localparam logic [STAT_W-1:0] ST_MISS = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

  // how the staged result is formed
  typedef enum logic [2:0] {
    RES_NONE,
    RES_MISS,
    RES_FULL,
    RES_DONE0,
    RES_VALUE,
    RES_FOUND
  } res_op_t;

  // controller to datapath
  typedef struct packed {
    logic    accept;
    logic    wr_append;
    logic    shift_wr;
    logic    ptr_inc;
    logic    dec_count;
    logic    load_out;
    res_op_t res_op;
  } ole_cmd_t;

  // datapath to controller
  typedef struct packed {
    kind_t kind;
    logic  pos_miss;
    logic  full;
    logic  empty;
    logic  ptr_ge_cnt;
    logic  match;
    logic  out_free;
  } ole_sts_t;

endpackage

[rtl/ole_ram.sv]
// Generic simple dual-port RAM, registered read.
module ole_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[rtl/ole_ctrl.sv]
// Command sequencer: one command at a time, RAM walked one entry per cycle.
module ole_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  ole_pkg::ole_sts_t sts,
  output ole_pkg::ole_cmd_t cmd
);
  import ole_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_ISSUE = 7'b0000010,
    S_READ  = 7'b0000100,
    S_DHEAD = 7'b0001000,
    S_SHIFT = 7'b0010000,
    S_FIND  = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  kind_t  kind_r, kind_nxt;

  assign in_tready = (state_r == S_IDLE);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    kind_nxt  = kind_r;
    cmd       = '0;
    cmd.res_op = RES_NONE;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          kind_nxt   = sts.kind;
          state_nxt  = S_DONE;
          case (sts.kind)
            KIND_APPEND: begin
              if (sts.full) begin
                cmd.res_op = RES_FULL;
              end else begin
                cmd.wr_append = 1'b1;
                cmd.res_op    = RES_DONE0;
              end
            end
            KIND_READ, KIND_DELETE: begin
              if (sts.pos_miss) cmd.res_op = RES_MISS;
              else              state_nxt  = S_ISSUE;
            end
            default: begin
              if (sts.empty) cmd.res_op = RES_MISS;
              else           state_nxt  = S_ISSUE;
            end
          endcase
        end
      end
      // first RAM read is in flight
      S_ISSUE: begin
        cmd.ptr_inc = 1'b1;
        case (kind_r)
          KIND_READ:   state_nxt = S_READ;
          KIND_DELETE: state_nxt = S_DHEAD;
          default:     state_nxt = S_FIND;
        endcase
      end
      S_READ: begin
        cmd.res_op = RES_VALUE;
        state_nxt  = S_DONE;
      end
      // capture the removed word, start moving the tail down
      S_DHEAD: begin
        cmd.res_op  = RES_VALUE;
        cmd.ptr_inc = 1'b1;
        if (sts.ptr_ge_cnt) begin
          cmd.dec_count = 1'b1;
          state_nxt     = S_DONE;
        end else begin
          state_nxt = S_SHIFT;
        end
      end
      S_SHIFT: begin
        cmd.shift_wr = 1'b1;
        cmd.ptr_inc  = 1'b1;
        if (sts.ptr_ge_cnt) begin
          cmd.dec_count = 1'b1;
          state_nxt     = S_DONE;
        end
      end
      S_FIND: begin
        if (sts.match) begin
          cmd.res_op = RES_FOUND;
          state_nxt  = S_DONE;
        end else if (sts.ptr_ge_cnt) begin
          cmd.res_op = RES_MISS;
          state_nxt  = S_DONE;
        end else begin
          cmd.ptr_inc = 1'b1;
        end
      end
      // hand the result to the output register once it is free
      S_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
  end

endmodule

[rtl/ole_dp.sv]
// Datapath: entry RAM, count, walk pointer, result staging and output register.
module ole_dp #(
  parameter int DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  ole_pkg::ole_cmd_t                cmd,
  output ole_pkg::ole_sts_t                sts,
  input  logic [ole_pkg::IN_DATA_W-1:0]    in_tdata,
  input  logic [ole_pkg::KIND_W-1:0]       in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [ole_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic [ole_pkg::STAT_W-1:0]       out_tuser
);
  import ole_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (CW > POS_W) ? CW : POS_W;
  localparam int YW = (CW > CNT_W) ? CW : CNT_W;

  // input fields
  logic [POS_W-1:0] in_pos;
  logic [VAL_W-1:0] in_val;
  assign in_pos = in_tdata[POS_W-1:0];
  assign in_val = in_tdata[POS_W+VAL_W-1:POS_W];

  logic [CW-1:0]     count_r, count_nxt;
  logic [CW-1:0]     ptr_r, ptr_nxt;
  logic [CW-1:0]     ptr_m1, ptr_m2;
  logic [VAL_W-1:0]  val_r;
  logic [VAL_W-1:0]  rd_data;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [VAL_W-1:0]  wr_data;
  logic [XW-1:0]     pos_x, cnt_x, ptr_m1_x;
  logic [YW-1:0]     cnt_y;

  logic [STAT_W-1:0] res_status_r;
  logic [VAL_W-1:0]  res_value_r;
  logic [POS_W-1:0]  res_pos_r;
  logic              out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0] out_status_r;
  logic [VAL_W-1:0]  out_value_r;
  logic [POS_W-1:0]  out_pos_r;
  logic [CNT_W-1:0]  out_cnt_r;

  assign ptr_m1   = ptr_r - CW'(1);
  assign ptr_m2   = ptr_r - CW'(2);
  assign pos_x    = XW'(in_pos);
  assign cnt_x    = XW'(count_r);
  assign ptr_m1_x = XW'(ptr_m1);
  assign cnt_y    = YW'(count_r);

  // RAM ports: append writes at the tail, shift writes one below the source
  assign wr_en   = cmd.wr_append | cmd.shift_wr;
  assign wr_addr = cmd.wr_append ? count_r[AW-1:0] : ptr_m2[AW-1:0];
  assign wr_data = cmd.wr_append ? in_val : rd_data;

  ole_ram #(
    .WIDTH (VAL_W),
    .DEPTH (DEPTH)
  ) u_entries (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (ptr_r[AW-1:0]),
    .rd_data (rd_data)
  );

  // status to the controller
  assign sts.kind       = kind_t'(in_tuser);
  assign sts.pos_miss   = (pos_x >= cnt_x);
  assign sts.full       = (count_r == CW'(DEPTH));
  assign sts.empty      = (count_r == '0);
  assign sts.ptr_ge_cnt = (ptr_r >= count_r);
  assign sts.match      = (rd_data == val_r);
  assign sts.out_free   = !out_valid_r || out_tready;

  // count and pointer
  always_comb begin
    count_nxt = count_r;
    if (cmd.wr_append)      count_nxt = count_r + CW'(1);
    else if (cmd.dec_count) count_nxt = count_r - CW'(1);
  end

  always_comb begin
    ptr_nxt = ptr_r;
    if (cmd.accept) begin
      ptr_nxt = (sts.kind == KIND_FIND) ? '0 : pos_x[CW-1:0];
    end else if (cmd.ptr_inc) begin
      ptr_nxt = ptr_r + CW'(1);
    end
  end

  assign out_valid_nxt = cmd.load_out ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    ptr_r <= ptr_nxt;
    if (cmd.accept) begin
      val_r <= in_val;
    end
    case (cmd.res_op)
      RES_MISS: begin
        res_status_r <= ST_MISS;
        res_value_r  <= '0;
        res_pos_r    <= '0;
      end
      RES_FULL: begin
        res_status_r <= ST_FULL;
        res_value_r  <= '0;
        res_pos_r    <= '0;
      end
      RES_DONE0: begin
        res_status_r <= ST_DONE;
        res_value_r  <= '0;
        res_pos_r    <= '0;
      end
      RES_VALUE: begin
        res_status_r <= ST_DONE;
        res_value_r  <= rd_data;
        res_pos_r    <= '0;
      end
      RES_FOUND: begin
        res_status_r <= ST_DONE;
        res_value_r  <= val_r;
        res_pos_r    <= ptr_m1_x[POS_W-1:0];
      end
      default: ;
    endcase
    if (cmd.load_out) begin
      out_status_r <= res_status_r;
      out_value_r  <= res_value_r;
      out_pos_r    <= res_pos_r;
      out_cnt_r    <= cnt_y[CNT_W-1:0];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = OUT_DATA_W'({out_cnt_r, out_pos_r, out_value_r});

endmodule

[rtl/ordered_list_engine.sv]
// Channel | Dir | tdata (low bit up)                      | tuser
// in_     | in  | position_in[3:0], value_in[35:4]        | kind[1:0]
// out_    | out | value_out[31:0], position_out[35:32],   | status[1:0]
//         |     | entry_count[40:36]                      |
//
// One command at a time. Append and early misses finish without a RAM read; read,
// delete and find walk the single RAM read port one entry per cycle, delete moving
// each later entry down and find comparing each entry until a match or the end.
// Reset clears the entry count, output valid and sequencer state; the entry RAM is not cleared.
// A new command is taken while a finished result waits on out_tready; the
// following result then holds in the sequencer until the output register frees.
module ordered_list_engine #(
  parameter int DEPTH = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [ole_pkg::IN_DATA_W-1:0]  in_tdata,  // position_in, value_in
  input  logic [ole_pkg::KIND_W-1:0]     in_tuser,  // kind
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [ole_pkg::OUT_DATA_W-1:0] out_tdata, // value_out, position_out, entry_count
  output logic [ole_pkg::STAT_W-1:0]     out_tuser  // status
);
  import ole_pkg::*;

`include "ordered_list_engine_assert.svh"

  localparam int CW = $clog2(DEPTH + 1);
  localparam int YW = (CW > CNT_W) ? CW : CNT_W;
  localparam logic [YW-1:0]    DEPTH_X   = YW'(DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_CNT = DEPTH_X[CNT_W-1:0];

  ole_cmd_t cmd;
  ole_sts_t sts;

  ole_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ole_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // an accepted command leaves the sequencer busy in the cycle after acceptance
  `OLE_ASSERT_NXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready)
  // miss and full results carry zero value and position
  `OLE_ASSERT_IMP(a_miss_zero, out_tvalid && (out_tuser != ST_DONE), out_tdata[35:0] == 36'd0)
  // a full report only when the list is at capacity
  `OLE_ASSERT_IMP(a_full_at_cap, out_tvalid && (out_tuser == ST_FULL), out_tdata[40:36] == DEPTH_CNT)
  // the sequencer never loads a result over one that is still waiting
  `OLE_ASSERT_IMP(a_no_overrun, cmd.load_out, !out_tvalid || out_tready)

endmodule

[tb/testbench.sv]
module testbench;
  import ole_pkg::*;

  localparam int DEPTH = 16;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;   // position_in[3:0], value_in[35:4]
  logic [KIND_W-1:0]     in_tuser;   // kind[1:0]
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;  // value_out[31:0], position_out[35:32], entry_count[40:36]
  logic [STAT_W-1:0]     out_tuser;  // status[1:0]

  // one result transaction, as the list would report it
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [VAL_W-1:0]  value;
    logic [POS_W-1:0]  position;
    logic [CNT_W-1:0]  count;
  } list_result_t;

  // directed row: issued reps times; typed rows carry their own expectation
  typedef struct {
    kind_t             kind;
    logic [POS_W-1:0]  pos;
    logic [VAL_W-1:0]  val;
    int                reps;
    bit                typed;
    list_result_t      want;
  } directed_row_t;

  localparam list_result_t NO_WANT = '{default: '0};

  directed_row_t directed_rows [24] = '{
    // empty list: every lookup misses
    '{KIND_READ,   4'd0,  32'h0000_0000, 1, 1'b1, '{ST_MISS, 32'h0, 4'd0, 5'd0}},
    '{KIND_DELETE, 4'd0,  32'h0000_0000, 1, 1'b1, '{ST_MISS, 32'h0, 4'd0, 5'd0}},
    '{KIND_FIND,   4'd0,  32'h0000_0000, 1, 1'b1, '{ST_MISS, 32'h0, 4'd0, 5'd0}},
    // value extremes
    '{KIND_APPEND, 4'd0,  32'h7fff_ffff, 1, 1'b1, '{ST_DONE, 32'h0, 4'd0, 5'd1}},
    '{KIND_APPEND, 4'd0,  32'h8000_0000, 1, 1'b1, '{ST_DONE, 32'h0, 4'd0, 5'd2}},
    '{KIND_APPEND, 4'd0,  32'h0000_0000, 1, 1'b1, '{ST_DONE, 32'h0, 4'd0, 5'd3}},
    '{KIND_APPEND, 4'd0,  32'hffff_ffff, 1, 1'b1, '{ST_DONE, 32'h0, 4'd0, 5'd4}},
    '{KIND_READ,   4'd1,  32'h0000_0000, 1, 1'b1, '{ST_DONE, 32'h8000_0000, 4'd0, 5'd4}},
    '{KIND_FIND,   4'd0,  32'hffff_ffff, 1, 1'b1, '{ST_DONE, 32'hffff_ffff, 4'd3, 5'd4}},
    '{KIND_FIND,   4'd0,  32'h1234_5678, 1, 1'b1, '{ST_MISS, 32'h0, 4'd0, 5'd4}},
    '{KIND_READ,   4'd15, 32'h0000_0000, 1, 1'b1, '{ST_MISS, 32'h0, 4'd0, 5'd4}},
    '{KIND_DELETE, 4'd0,  32'h0000_0000, 1, 1'b1, '{ST_DONE, 32'h7fff_ffff, 4'd0, 5'd3}},
    '{KIND_READ,   4'd0,  32'h0000_0000, 1, 1'b0, NO_WANT},
    // fill to capacity with duplicates, then overflow
    '{KIND_APPEND, 4'd0,  32'h5a5a_0000, 13, 1'b0, NO_WANT},
    '{KIND_APPEND, 4'd0,  32'h0000_0001, 1, 1'b1, '{ST_FULL, 32'h0, 4'd0, 5'd16}},
    '{KIND_READ,   4'd15, 32'h0000_0000, 1, 1'b0, NO_WANT},
    '{KIND_FIND,   4'd0,  32'h5a5a_0000, 1, 1'b0, NO_WANT},
    '{KIND_DELETE, 4'd15, 32'h0000_0000, 1, 1'b0, NO_WANT},
    '{KIND_DELETE, 4'd15, 32'h0000_0000, 1, 1'b1, '{ST_MISS, 32'h0, 4'd0, 5'd15}},
    '{KIND_DELETE, 4'd4,  32'h0000_0000, 1, 1'b0, NO_WANT},
    '{KIND_FIND,   4'd0,  32'h0000_0000, 1, 1'b0, NO_WANT},
    '{KIND_READ,   4'd14, 32'h0000_0000, 1, 1'b1, '{ST_MISS, 32'h0, 4'd0, 5'd14}},
    '{KIND_APPEND, 4'd0,  32'hffff_fffe, 1, 1'b0, NO_WANT},
    '{KIND_READ,   4'd7,  32'h0000_0000, 1, 1'b0, NO_WANT}
  };

  // shadow copy of the list
  logic [VAL_W-1:0] list_words [DEPTH];
  int               list_len;

  list_result_t     pending_results [$];
  int               mismatches;
  int               idle_pct;
  int               stall_pct;
  int               hold_len;

  ordered_list_engine #(.DEPTH(DEPTH)) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run limit
  initial begin
    #1600000;
    $display("simulation failed");
    $finish;
  end

  // apply one command to the shadow list and return its result
  function automatic list_result_t apply_command(kind_t kind, logic [POS_W-1:0] pos,
                                                 logic [VAL_W-1:0] val);
    list_result_t res;
    int           i;
    res = '{default: '0};
    res.status = ST_MISS;
    case (kind)
      KIND_APPEND: begin
        if (list_len >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          list_words[list_len] = val;
          list_len++;
          res.status = ST_DONE;
        end
      end
      KIND_READ: begin
        if (pos < list_len) begin
          res.status = ST_DONE;
          res.value  = list_words[pos];
        end
      end
      KIND_DELETE: begin
        if (pos < list_len) begin
          res.status = ST_DONE;
          res.value  = list_words[pos];
          // close the gap
          for (i = pos; i + 1 < list_len; i++) list_words[i] = list_words[i + 1];
          list_len--;
        end
      end
      default: begin
        // first match wins
        for (i = 0; i < list_len; i++) begin
          if (list_words[i] == val) begin
            res.status   = ST_DONE;
            res.value    = val;
            res.position = i[POS_W-1:0];
            break;
          end
        end
      end
    endcase
    res.count = list_len[CNT_W-1:0];
    return res;
  endfunction

  // values biased toward extremes and small repeats so finds hit
  function automatic logic [VAL_W-1:0] sample_value();
    case ($urandom_range(9))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      4, 5:    return VAL_W'($urandom_range(7));
      default: return $urandom();
    endcase
  endfunction

  // offer one command transaction and record what it should produce
  task automatic send_command(kind_t kind, logic [POS_W-1:0] pos, logic [VAL_W-1:0] val,
                              bit typed, list_result_t want);
    list_result_t res;
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_DATA_W - VAL_W - POS_W){1'b0}}, val, pos};
    in_tuser  <= kind;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    res = apply_command(kind, pos, val);
    pending_results.push_back(typed ? want : res);
  endtask

  // stop offering until every expected result has come back
  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic flag_field(string name, logic [VAL_W-1:0] want, logic [VAL_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    int hold_cnt;
    hold_cnt   = 0;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_len != 0) begin
        hold_cnt = hold_len;
        hold_len = 0;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    list_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, actual status %h value %h", $time, out_tuser,
                 out_tdata[31:0]);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        flag_field("status", VAL_W'(want.status), VAL_W'(out_tuser));
        flag_field("value_out", want.value, out_tdata[31:0]);
        flag_field("position_out", VAL_W'(want.position), VAL_W'(out_tdata[35:32]));
        flag_field("entry_count", VAL_W'(want.count), VAL_W'(out_tdata[40:36]));
      end
    end
  end

  // stimulus
  initial begin
    int               phase_idle  [4];
    int               phase_stall [4];
    int               r;
    int               n;
    int               app_pct;
    kind_t            kind;
    logic [POS_W-1:0] pos;
    logic [VAL_W-1:0] val;

    phase_idle  = '{0, 88, 0, 16};
    phase_stall = '{0, 0, 88, 16};
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = '0;
    list_len   = 0;
    mismatches = 0;
    idle_pct   = 0;
    stall_pct  = 0;
    hold_len   = 0;
    foreach (list_words[i]) list_words[i] = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    foreach (directed_rows[i]) begin
      for (n = 0; n < directed_rows[i].reps; n++) begin
        send_command(directed_rows[i].kind, directed_rows[i].pos, directed_rows[i].val,
                     directed_rows[i].typed, directed_rows[i].want);
      end
    end

    // random commands over four phases of source idling and receiver stalls
    for (int ph = 0; ph < 4; ph++) begin
      drain_results();
      idle_pct  = phase_idle[ph];
      stall_pct = phase_stall[ph];
      for (n = 0; n < 150; n++) begin
        // long receiver hold-off while commands keep coming
        if (ph == 0 && n == 20) hold_len = 400;
        app_pct = (list_len < 4) ? 60 : ((list_len >= 14) ? 25 : 35);
        r = $urandom_range(99);
        if (r < app_pct) kind = KIND_APPEND;
        else kind = kind_t'($urandom_range(3, 1));
        if (list_len > 0 && $urandom_range(99) < 85) pos = POS_W'($urandom_range(list_len - 1));
        else pos = POS_W'($urandom_range(15));
        if (kind == KIND_FIND && list_len > 0 && $urandom_range(99) < 65)
          val = list_words[$urandom_range(list_len - 1)];
        else
          val = sample_value();
        send_command(kind, pos, val, 1'b0, NO_WANT);
      end
    end

    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
